FILE: hw/rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: op and status codes, field widths
// and default sizes. No dependencies.
package ffha_pkg;

    localparam int HEAP_WORDS_DEF = 4096;

    localparam int OP_W    = 2;
    localparam int BYTES_W = 16;
    localparam int ADDR_W  = 12;
    localparam int ST_W    = 2;
    localparam int COPY_W  = 14;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_OOM      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTALLOC = 2'd3;

    localparam int MIN_BYTES = 32;

endpackage

FILE: hw/rtl/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/first_fit_heap_allocator_core.sv
// Top level of the first-fit boundary-tag heap allocator: header walker,
// allocate / free / reallocate sequencer and result register.
// Depends on ffha_pkg and ffha_ram.
//
//  channel | dir | ports                      | word
//  s_      | in  | s_tvalid s_tready s_tdata  | op, request_bytes, block_address
//  m_      | out | m_tvalid m_tready m_tdata  | status, address, copy_bytes
//
// After reset a clearing pass writes every heap word with s_tready low. Each
// header visited is read from the RAM, then compared and stepped in the shared
// adder; a grant adds a write state, and a release reads each header while
// merging, then fetches the free run above. Allocate and free take one walk,
// reallocate up to three. One word is worked at a time; the result register
// lets the next word enter while a result waits on m_tready.
module first_fit_heap_allocator_core #(
    parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[1:0], request_bytes[17:2], block_address[29:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], address[13:2], copy_bytes[27:14]
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int DW = AW + 1;
    localparam int XW = DW + 1;
    localparam int CW = (XW > ffha_pkg::ADDR_W + 1) ? XW : ffha_pkg::ADDR_W + 1;
    localparam int SW = (DW > ffha_pkg::BYTES_W) ? DW + 1 : ffha_pkg::BYTES_W + 1;
    localparam int HW = (DW + 2 > ffha_pkg::BYTES_W) ? DW + 2 : ffha_pkg::BYTES_W;
    localparam int WW = ffha_pkg::BYTES_W - 1;

    localparam logic [AW-1:0]        TOP      = AW'(HEAP_WORDS - 1);
    localparam logic signed [DW-1:0] INIT_HDR = DW'(-(HEAP_WORDS - 2));

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_FD_RD = 4'd3;
    localparam logic [3:0] S_FD_EV = 4'd4;
    localparam logic [3:0] S_GR_RD = 4'd5;
    localparam logic [3:0] S_GR_EV = 4'd6;
    localparam logic [3:0] S_GR_WR = 4'd7;
    localparam logic [3:0] S_MD_RD = 4'd8;
    localparam logic [3:0] S_MD_EV = 4'd9;
    localparam logic [3:0] S_Q_RD  = 4'd10;
    localparam logic [3:0] S_Q_EV  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]                     state_reg, state_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [ffha_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ffha_pkg::BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [ffha_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [WW-1:0]                  w_reg, w_next;
    logic [AW-1:0]                  p_reg, p_next;
    logic [AW-1:0]                  q_reg, q_next;
    logic                           qv_reg, qv_next;
    logic                           inq_reg, inq_next;
    logic                           pass_reg, pass_next;
    logic signed [DW-1:0]           len_reg, len_next;
    logic [ffha_pkg::COPY_W-1:0]    cp_reg, cp_next;
    logic [ffha_pkg::ST_W-1:0]      st_reg, st_next;
    logic [ffha_pkg::ST_W-1:0]      fin_reg, fin_next;
    logic [AW-1:0]                  res_reg, res_next;
    logic [ffha_pkg::COPY_W-1:0]    copy_reg, copy_next;
    logic                           mv_reg, mv_next;
    logic [ffha_pkg::ST_W-1:0]      ost_reg, ost_next;
    logic [ffha_pkg::ADDR_W-1:0]    oaddr_reg, oaddr_next;
    logic [ffha_pkg::COPY_W-1:0]    ocopy_reg, ocopy_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic signed [DW-1:0]  wdata, rd_data;

    logic signed [XW-1:0]  p_x, h_x, step_x, md_x;
    logic signed [CW-1:0]  diff_c, addr_c;
    logic signed [SW-1:0]  hs, ws;
    logic signed [DW-1:0]  split_hdr;
    logic [AW-1:0]         np;
    logic [ffha_pkg::BYTES_W:0] need_sum;
    logic [ffha_pkg::BYTES_W-1:0] need;
    logic [HW-1:0]         have_h, need_h;
    logic                  is_realloc_full;

    ffha_ram #(
        .WIDTH (DW),
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // shared index and size arithmetic
    always_comb begin
        p_x    = $signed({2'b00, p_reg});
        h_x    = XW'(rd_data);
        step_x = (rd_data < 0) ? (p_x + h_x - XW'(1)) : (p_x - h_x - XW'(1));
        md_x   = p_x + XW'(len_reg) - XW'(1);
        diff_c = CW'(p_x - h_x);
        addr_c = $signed({{(CW - ffha_pkg::ADDR_W){1'b0}}, addr_reg});
        hs     = SW'(rd_data);
        ws     = $signed({{(SW - WW){1'b0}}, w_reg});
        split_hdr = DW'(hs + ws + SW'(1));
        np     = AW'(p_x + XW'(split_hdr) - XW'(1));
        need   = (bytes_reg < ffha_pkg::BYTES_W'(ffha_pkg::MIN_BYTES)) ?
                 ffha_pkg::BYTES_W'(ffha_pkg::MIN_BYTES) : bytes_reg;
        need_sum = {1'b0, need} + (ffha_pkg::BYTES_W + 1)'(3);
        have_h = HW'({rd_data, 2'b00});
        need_h = HW'(need);
        is_realloc_full = (op_reg == ffha_pkg::OP_REALLOC) && (bytes_reg != '0);
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        bytes_next = bytes_reg;
        addr_next  = addr_reg;
        w_next     = w_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        qv_next    = qv_reg;
        inq_next   = inq_reg;
        pass_next  = pass_reg;
        len_next   = len_reg;
        cp_next    = cp_reg;
        st_next    = st_reg;
        fin_next   = fin_reg;
        res_next   = res_reg;
        copy_next  = copy_reg;
        mv_next    = mv_reg;
        ost_next   = ost_reg;
        oaddr_next = oaddr_reg;
        ocopy_next = ocopy_reg;
        we    = 1'b0;
        waddr = p_reg;
        wdata = '0;
        raddr = p_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = (clr_reg == TOP) ? INIT_HDR : '0;
                if (clr_reg == TOP) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[1:0];
                    bytes_next = s_tdata[17:2];
                    addr_next  = s_tdata[29:18];
                    st_next    = ffha_pkg::ST_NULL;
                    fin_next   = ffha_pkg::ST_OK;
                    res_next   = '0;
                    copy_next  = '0;
                    pass_next  = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                w_next   = need_sum[ffha_pkg::BYTES_W:2];
                p_next   = TOP;
                qv_next  = 1'b0;
                inq_next = 1'b0;
                case (op_reg)
                    ffha_pkg::OP_ALLOC: begin
                        state_next = (bytes_reg == '0) ? S_OUT : S_GR_RD;
                    end
                    ffha_pkg::OP_FREE: begin
                        state_next = S_FD_RD;
                    end
                    ffha_pkg::OP_REALLOC: begin
                        if (addr_reg == '0) begin
                            state_next = (bytes_reg == '0) ? S_OUT : S_GR_RD;
                        end else begin
                            if (bytes_reg == '0) begin
                                fin_next = ffha_pkg::ST_NULL;
                            end
                            state_next = S_FD_RD;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_FD_RD: begin
                raddr      = p_reg;
                state_next = S_FD_EV;
            end
            S_FD_EV: begin
                if (rd_data == '0) begin
                    st_next    = pass_reg ? ffha_pkg::ST_OK : ffha_pkg::ST_NOTALLOC;
                    state_next = S_OUT;
                end else if (rd_data < 0) begin
                    if (!qv_reg) begin
                        q_next  = p_reg;
                        qv_next = 1'b1;
                    end
                    p_next     = AW'(step_x);
                    state_next = S_FD_RD;
                end else if (diff_c == addr_c) begin
                    if (is_realloc_full && !pass_reg) begin
                        // remember copy length, then look for the new block
                        cp_next    = ffha_pkg::COPY_W'((have_h > need_h) ? need_h : have_h);
                        pass_next  = 1'b1;
                        p_next     = TOP;
                        state_next = S_GR_RD;
                    end else begin
                        len_next   = -rd_data;
                        inq_next   = 1'b0;
                        state_next = S_MD_RD;
                    end
                end else begin
                    qv_next    = 1'b0;
                    p_next     = AW'(step_x);
                    state_next = S_FD_RD;
                end
            end
            S_GR_RD: begin
                raddr      = p_reg;
                state_next = S_GR_EV;
            end
            S_GR_EV: begin
                if (rd_data == '0) begin
                    st_next    = ffha_pkg::ST_OOM;
                    state_next = S_OUT;
                end else if ((rd_data < 0) && (-hs >= ws)) begin
                    we    = 1'b1;
                    waddr = p_reg;
                    if (-hs <= ws + SW'(1)) begin
                        wdata = -rd_data;
                        p_next = AW'(p_x + h_x);
                        state_next = S_GR_WR;
                        inq_next = 1'b1;
                    end else begin
                        wdata      = split_hdr;
                        p_next     = np;
                        inq_next   = 1'b0;
                        state_next = S_GR_WR;
                    end
                end else begin
                    p_next     = AW'(step_x);
                    state_next = S_GR_RD;
                end
            end
            S_GR_WR: begin
                // inq_reg set: whole block granted, p_reg already the data start
                if (!inq_reg) begin
                    we    = 1'b1;
                    waddr = p_reg;
                    wdata = DW'(w_reg);
                end
                res_next = inq_reg ? p_reg : (p_reg - AW'(w_reg));
                st_next  = ffha_pkg::ST_OK;
                inq_next = 1'b0;
                if (is_realloc_full && (addr_reg != '0)) begin
                    copy_next  = cp_reg;
                    p_next     = TOP;
                    qv_next    = 1'b0;
                    state_next = S_FD_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_MD_RD: begin
                raddr      = AW'(md_x);
                state_next = S_MD_EV;
            end
            S_MD_EV: begin
                if (rd_data < 0) begin
                    len_next   = len_reg + rd_data - DW'(1);
                    state_next = S_MD_RD;
                end else begin
                    we    = 1'b1;
                    waddr = p_reg;
                    wdata = len_reg;
                    if (qv_reg && !inq_reg) begin
                        state_next = S_Q_RD;
                    end else begin
                        st_next    = fin_reg;
                        state_next = S_OUT;
                    end
                end
            end
            S_Q_RD: begin
                raddr      = q_reg;
                state_next = S_Q_EV;
            end
            S_Q_EV: begin
                // pull the free run above down over the released block
                len_next   = rd_data;
                p_next     = q_reg;
                inq_next   = 1'b1;
                state_next = S_MD_RD;
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    ost_next   = st_reg;
                    oaddr_next = ffha_pkg::ADDR_W'(res_reg);
                    ocopy_next = copy_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        bytes_reg <= bytes_next;
        addr_reg  <= addr_next;
        w_reg     <= w_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        qv_reg    <= qv_next;
        inq_reg   <= inq_next;
        pass_reg  <= pass_next;
        len_reg   <= len_next;
        cp_reg    <= cp_next;
        st_reg    <= st_next;
        fin_reg   <= fin_next;
        res_reg   <= res_next;
        copy_reg  <= copy_next;
        ost_reg   <= ost_next;
        oaddr_reg <= oaddr_next;
        ocopy_reg <= ocopy_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, ocopy_reg, oaddr_reg, ost_reg};

endmodule

FILE: hw/rtl/ffha_checker.sv
// Port-level checks for first_fit_heap_allocator_core and the bind that
// attaches them. Depends on ffha_pkg.
module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // clearing pass holds the input side off right after reset
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input ready during clearing pass");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ffha_pkg::ST_OK) |-> (m_tdata[13:2] == '0))
        else $error("address given with a failing status");

    a_copy_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[27:14] != '0) |->
            (m_tdata[1:0] == ffha_pkg::ST_OK) && (m_tdata[13:2] != '0))
        else $error("copy length without a granted block");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
